// ----- design/jpq_pkg.sv -----
// Package for the job priority queue: job and result record types,
// mode and status codes, sequencer states. No dependencies.
`default_nettype none

package jpq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  job_priority;
        logic [21:0] job_process;
        logic [7:0]  job_producer;
        logic [1:0]  job_duration;
        logic [16:0] job_tag;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic        out_valid;
        logic [3:0]  out_priority;
        logic [21:0] out_process;
        logic [7:0]  out_producer;
        logic [1:0]  out_duration;
        logic [16:0] out_tag;
        logic [3:0]  occupancy;
    } result_t;

    // One queue slot, 53 bits.
    typedef struct packed {
        logic [3:0]  prio;
        logic [21:0] proc_id;
        logic [7:0]  producer;
        logic [1:0]  dur;
        logic [16:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REM_HEAD,
        ST_REM_MV
    } state_t;

endpackage

`default_nettype wire

// ----- design/jpq_store.sv -----
// Slot memory of the job priority queue: one write port, one read port
// with registered read data. Depends on jpq_pkg.
`default_nettype none

module jpq_store #(
    parameter int DEPTH = jpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire jpq_pkg::entry_t            wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output jpq_pkg::entry_t                 rd_data
);

    jpq_pkg::entry_t mem [DEPTH];
    jpq_pkg::entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

// ----- design/job_priority_queue.sv -----
// Job priority queue top level: sequencer, occupancy count and result register
// around the slot memory. Depends on jpq_pkg and jpq_store.
//
// Bounded queue of job records kept sorted by descending priority in a slot memory
// with one read and one write port; equal priorities leave in arrival order. A
// command is taken when start is high and busy is low. Each command gives one
// result, shown on result for exactly one cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. A new command may be started in
// the cycle that done is high. Insert into an empty queue or when full, and remove
// from an empty queue, finish from idle without raising busy; any other command
// holds busy high until it finishes. Other inserts walk from the tail toward the
// head, moving each lower-priority job one slot back; removes read the head, then
// pull each later job one slot forward. The slot memory moves one slot per cycle
// through one read and one write port, with one priority compare per step.
`default_nettype none

module job_priority_queue #(
    parameter int DEPTH = jpq_pkg::DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire jpq_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output jpq_pkg::result_t      result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jpq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    idx_reg, idx_next;
    jpq_pkg::entry_t  new_reg, new_next;
    jpq_pkg::result_t res_reg, res_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    jpq_pkg::entry_t  wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    jpq_pkg::entry_t  rd_data;
    logic             keep_place;

    jpq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Insert-walk compare: the new job stays behind a slot of equal or higher priority.
    assign keep_place = (rd_data.prio >= new_reg.prio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jpq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        new_reg <= new_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = new_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;

        unique case (state_reg)
            jpq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    new_next.prio     = cmd.job_priority;
                    new_next.proc_id  = cmd.job_process;
                    new_next.producer = cmd.job_producer;
                    new_next.dur      = cmd.job_duration;
                    new_next.tag      = cmd.job_tag;
                    res_next          = '0;
                    res_next.status   = jpq_pkg::STATUS_DONE;
                    res_next.occupancy = 4'(cnt_reg);
                    if (cmd.mode == jpq_pkg::MODE_INSERT)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            // drop the job
                            res_next.status = jpq_pkg::STATUS_FULL;
                            done_next       = 1'b1;
                        end
                        else if (cnt_reg == '0)
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = '0;
                            wr_data   = new_next;
                            cnt_next  = cnt_reg + CW'(1);
                            res_next.occupancy = 4'(cnt_next);
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // walk from the tail toward the head
                            idx_next   = AW'(cnt_reg);
                            rd_en      = 1'b1;
                            rd_addr    = AW'(cnt_reg - CW'(1));
                            state_next = jpq_pkg::ST_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next.status = jpq_pkg::STATUS_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = jpq_pkg::ST_REM_HEAD;
                        end
                    end
                end
            end

            jpq_pkg::ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (keep_place)
                begin
                    wr_data    = new_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    res_next.occupancy = 4'(cnt_next);
                    done_next  = 1'b1;
                    state_next = jpq_pkg::ST_IDLE;
                end
                else
                begin
                    // advance the lower-priority slot one place toward the tail
                    wr_data  = rd_data;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = jpq_pkg::ST_INS_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - AW'(2);
                    end
                end
            end

            jpq_pkg::ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_data    = new_reg;
                cnt_next   = cnt_reg + CW'(1);
                res_next.occupancy = 4'(cnt_next);
                done_next  = 1'b1;
                state_next = jpq_pkg::ST_IDLE;
            end

            jpq_pkg::ST_REM_HEAD:
            begin
                res_next.out_valid    = 1'b1;
                res_next.out_priority = rd_data.prio;
                res_next.out_process  = rd_data.proc_id;
                res_next.out_producer = rd_data.producer;
                res_next.out_duration = rd_data.dur;
                res_next.out_tag      = rd_data.tag;
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = '0;
                    res_next.occupancy = 4'(cnt_next);
                    done_next  = 1'b1;
                    state_next = jpq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = AW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    state_next = jpq_pkg::ST_REM_MV;
                end
            end

            jpq_pkg::ST_REM_MV:
            begin
                // pull each slot one place toward the head
                wr_en   = 1'b1;
                wr_addr = idx_reg - AW'(1);
                wr_data = rd_data;
                if (CW'(idx_reg) + CW'(1) == cnt_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    res_next.occupancy = 4'(cnt_next);
                    done_next  = 1'b1;
                    state_next = jpq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = jpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != jpq_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("occupancy count above depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer still running");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == jpq_pkg::STATUS_FULL) |-> result.occupancy == 4'(DEPTH))
        else $error("full status with queue not full");

    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_valid) |-> result.status == jpq_pkg::STATUS_DONE)
        else $error("removed job carried with error status");

endmodule

`default_nettype wire

// ----- dv/job_priority_queue_checker.sv -----
// Checker for the job priority queue: keeps its own sorted copy of the queue,
// predicts one result per accepted command and compares it with the block's result.
// Depends on jpq_pkg.
module job_priority_queue_checker #(
    parameter int DEPTH = jpq_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  jpq_pkg::cmd_t    cmd,
    input  logic             done,
    input  jpq_pkg::result_t result,
    output int               errors,
    output int               pending,
    output int               n_removed,
    output int               n_full,
    output int               n_empty
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  prio;
        logic [21:0] proc_id;
        logic [7:0]  producer;
        logic [1:0]  dur;
        logic [16:0] tag;
    } job_rec_t;

    job_rec_t         sched_jobs[$];        // predicted queue contents, head first
    jpq_pkg::result_t expected_results[$];
    jpq_pkg::result_t want;

    initial
    begin
        errors    = 0;
        pending   = 0;
        n_removed = 0;
        n_full    = 0;
        n_empty   = 0;
    end

    // Apply one command to the predicted queue and return the result it causes.
    function automatic jpq_pkg::result_t predict_queue_op(jpq_pkg::cmd_t c);
        jpq_pkg::result_t r;
        job_rec_t         j;
        int               pos;
        r = '0;
        r.status = jpq_pkg::STATUS_DONE;
        if (c.mode == jpq_pkg::MODE_INSERT)
        begin
            if (sched_jobs.size() >= DEPTH)
                r.status = jpq_pkg::STATUS_FULL;
            else
            begin
                j.prio     = c.job_priority;
                j.proc_id  = c.job_process;
                j.producer = c.job_producer;
                j.dur      = c.job_duration;
                j.tag      = c.job_tag;
                // land behind every job of equal or higher priority
                pos = 0;
                while (pos < sched_jobs.size() && sched_jobs[pos].prio >= j.prio)
                    pos++;
                sched_jobs.insert(pos, j);
            end
        end
        else if (sched_jobs.size() == 0)
            r.status = jpq_pkg::STATUS_EMPTY;
        else
        begin
            j = sched_jobs.pop_front();
            r.out_valid    = 1'b1;
            r.out_priority = j.prio;
            r.out_process  = j.proc_id;
            r.out_producer = j.producer;
            r.out_duration = j.dur;
            r.out_tag      = j.tag;
        end
        r.occupancy = 4'(sched_jobs.size());
        return r;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // compare before queuing, a command's result never lands on its own edge
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result strobe with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("out_valid", 32'(want.out_valid), 32'(result.out_valid));
                    check_field("out_priority", 32'(want.out_priority),
                                32'(result.out_priority));
                    check_field("out_process", 32'(want.out_process), 32'(result.out_process));
                    check_field("out_producer", 32'(want.out_producer),
                                32'(result.out_producer));
                    check_field("out_duration", 32'(want.out_duration),
                                32'(result.out_duration));
                    check_field("out_tag", 32'(want.out_tag), 32'(result.out_tag));
                    check_field("occupancy", 32'(want.occupancy), 32'(result.occupancy));
                    if (want.out_valid)
                        n_removed++;
                    if (want.status == jpq_pkg::STATUS_FULL)
                        n_full++;
                    if (want.status == jpq_pkg::STATUS_EMPTY)
                        n_empty++;
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_queue_op(cmd));
            pending = expected_results.size();
        end
    end

endmodule

// ----- dv/job_priority_queue_tb.sv -----
// Testbench top for the job priority queue: clock, reset, directed and random
// command transfers and the verdict. Depends on jpq_pkg, job_priority_queue and
// job_priority_queue_checker.
module job_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = jpq_pkg::DEPTH_DEFAULT;
    localparam int N_RANDOM = 1600;

    logic             clk;
    logic             rst_n;
    logic             start;
    jpq_pkg::cmd_t    cmd;
    logic             busy;
    logic             done;
    jpq_pkg::result_t result;

    int errors;
    int pending;
    int n_removed;
    int n_full;
    int n_empty;
    int n_sent;

    job_priority_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    job_priority_queue_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .errors   (errors),
        .pending  (pending),
        .n_removed(n_removed),
        .n_full   (n_full),
        .n_empty  (n_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic jpq_pkg::cmd_t insert_job(logic [3:0] prio, logic [21:0] proc_id,
                                                 logic [7:0] producer, logic [1:0] dur,
                                                 logic [16:0] tag);
        jpq_pkg::cmd_t c;
        c.mode         = jpq_pkg::MODE_INSERT;
        c.job_priority = prio;
        c.job_process  = proc_id;
        c.job_producer = producer;
        c.job_duration = dur;
        c.job_tag      = tag;
        return c;
    endfunction

    // Payload of a remove is don't-care but still random.
    function automatic jpq_pkg::cmd_t random_cmd(bit is_remove);
        jpq_pkg::cmd_t c;
        logic [3:0]    prio;
        // narrow priorities half the time to get plenty of ties
        prio = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        c = insert_job(prio, 22'($urandom()), 8'($urandom()), 2'($urandom()),
                       17'($urandom_range(0, 17'h1FFFF)));
        if (is_remove)
            c.mode = jpq_pkg::MODE_REMOVE;
        return c;
    endfunction

    // Hold the command until the block takes it.
    task automatic send(jpq_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        jpq_pkg::cmd_t rm;
        int            k;
        int            burst;
        int            insert_pct;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = '0;
        n_sent = 0;
        rm     = random_cmd(1'b1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty remove, a tie, head landing, field extremes, fill,
        // full drop, then drain past empty
        send(rm);
        send(insert_job(4'd5, 22'd1, 8'd1, 2'd1, 17'd1));
        send(insert_job(4'hF, 22'h3FFFFF, 8'hFF, 2'd3, 17'h1FFFF));
        send(insert_job(4'd0, 22'd0, 8'd0, 2'd0, 17'd0));
        send(insert_job(4'd5, 22'd2, 8'd2, 2'd2, 17'd2));
        send(insert_job(4'd9, 22'h2AAAAA, 8'hAA, 2'd2, 17'h0AAAA));
        send(insert_job(4'd10, 22'h155555, 8'h55, 2'd1, 17'h15555));
        send(insert_job(4'd5, 22'd3, 8'd3, 2'd3, 17'd99999));
        send(insert_job(4'd1, 22'd4, 8'd4, 2'd0, 17'd4));
        send(insert_job(4'd12, 22'd5, 8'd5, 2'd1, 17'd5));
        for (k = 0; k <= DEPTH; k++)
            send(random_cmd(1'b1));

        // random: bursts leaning toward insert or remove so the queue
        // swings between empty and full
        k = 0;
        while (k < N_RANDOM)
        begin
            burst = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0: insert_pct = 25;
                1: insert_pct = 50;
                default: insert_pct = 80;
            endcase
            repeat (burst)
            begin
                send(random_cmd($urandom_range(0, 99) >= insert_pct));
                maybe_idle(k < 700 || k > 1000);
                k++;
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);

        $display("Sent %0d commands: %0d jobs removed, %0d inserts refused on a full queue,",
                 n_sent, n_removed, n_full);
        $display("%0d removes from an empty queue; %0d mismatches, %0d results missing",
                 n_empty, errors, pending);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
